[src/bmpd_pkg.sv]
// Shared types and constants for the BMP indexed pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_PIXEL         = 3'd0,
        ST_BAD_SIG       = 3'd1,
        ST_TOO_MANY_BITS = 3'd2,
        ST_COMPRESSED    = 3'd3,
        ST_BAD_DEPTH     = 3'd4,
        ST_TOO_LARGE     = 3'd5
    } status_t;

    // Kinds of work handed from the parser to the unpacker.
    typedef enum logic [1:0] {
        ENT_START = 2'd0,
        ENT_PIX   = 2'd1,
        ENT_ERR   = 2'd2
    } ent_kind_t;

    // One queue entry, without the image dimensions.
    typedef struct packed {
        ent_kind_t  kind;
        logic [7:0] data;
        logic [3:0] count;
        logic       last;
        status_t    code;
        logic       top_down;
        logic       depth_two;
    } ent_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;

    localparam int unsigned CFG_W          = 12;
    localparam logic [11:0] DISP_W_RESET   = 12'd800;
    localparam logic [11:0] DISP_H_RESET   = 12'd480;

    // Header layout, as byte positions of the last byte of each field.
    localparam logic [15:0] SIG_BM     = 16'h4D42;
    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_BPP    = 32'd29;
    localparam logic [31:0] POS_COMP   = 32'd33;
    localparam logic [31:0] HDR_END    = 32'd34;
    localparam logic [31:0] POS_MAX    = 32'hFFFF_FFFF;

    localparam logic [15:0] BPP_MAX    = 16'd4;
    localparam logic [15:0] BPP_ONE    = 16'd1;
    localparam logic [15:0] BPP_TWO    = 16'd2;
    localparam logic [3:0]  PPB_DEPTH1 = 4'd8;
    localparam logic [3:0]  PPB_DEPTH2 = 4'd4;

endpackage

`default_nettype wire

[src/bmpd_if.sv]
// Channel interfaces: file bytes in, pixel results out, configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface bmpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, data_byte, file_start, input ready);
    modport sink   (input valid, data_byte, file_start, output ready);
endinterface

interface bmpd_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [1:0]  pixel_color;
    logic [2:0]  status;
    logic        image_done;

    modport source (output valid, pixel_col, pixel_row, pixel_color, status, image_done,
                    input ready);
    modport sink   (input valid, pixel_col, pixel_row, pixel_color, status, image_done,
                    output ready);
endinterface

interface bmpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/bmpd_front.sv]
// Header parser: takes file bytes, checks the header and queues work for the unpacker.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_front
    import bmpd_pkg::*;
#(
    parameter int unsigned DIM_BITS = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          data_byte,
    input  wire logic                file_start,
    input  wire logic                q_full,
    output logic                     push,
    output ent_t                     ent,
    output logic [DIM_BITS-1:0]      ent_w,
    output logic [DIM_BITS-1:0]      ent_h
);

    localparam int unsigned LEFT_W = 2 * DIM_BITS;

    logic                accept;
    logic                halted_reg, halted_next, halted_e;
    logic [31:0]         pos_reg, pos_next, pos_e;
    logic [31:0]         fs_reg, fs_next, fs_e;
    logic [31:0]         off_reg, off_next, off_e;
    logic [DIM_BITS-1:0] w_reg, w_next, w_e;
    logic [DIM_BITS-1:0] h_reg, h_next, h_e;
    logic                td_reg, td_next, td_e;
    logic                d2_reg, d2_next, d2_e;
    logic                dok_reg, dok_next, dok_e;
    logic [LEFT_W-1:0]   left_reg, left_next, left_e;
    logic [LEFT_W-1:0]   area;
    logic                push_c;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && push_c;
    assign ent_w    = w_e;
    assign ent_h    = h_e;

    // A file start clears the parse before this byte is looked at.
    assign halted_e = file_start ? 1'b0 : halted_reg;
    assign pos_e    = file_start ? '0 : pos_reg;
    assign fs_e     = file_start ? '0 : fs_reg;
    assign off_e    = file_start ? '0 : off_reg;
    assign w_e      = file_start ? '0 : w_reg;
    assign h_e      = file_start ? '0 : h_reg;
    assign td_e     = file_start ? 1'b0 : td_reg;
    assign d2_e     = file_start ? 1'b0 : d2_reg;
    assign dok_e    = file_start ? 1'b0 : dok_reg;
    assign left_e   = file_start ? '0 : left_reg;

    assign area = w_e * h_e;

    always_comb
    begin
        logic [31:0] mag;
        logic [15:0] bpp;
        logic [3:0]  ppb;
        logic [3:0]  nb;

        halted_next = halted_e;
        pos_next    = pos_e;
        fs_next     = fs_e;
        off_next    = off_e;
        w_next      = w_e;
        h_next      = h_e;
        td_next     = td_e;
        d2_next     = d2_e;
        dok_next    = dok_e;
        left_next   = left_e;
        push_c      = 1'b0;
        ent         = '0;
        ent.kind    = ENT_PIX;
        ent.code    = ST_PIXEL;
        mag         = '0;
        bpp         = '0;
        ppb         = PPB_DEPTH1;
        nb          = '0;

        if (!halted_e)
        begin
            pos_next = (pos_e == POS_MAX) ? pos_e : pos_e + 32'd1;
            fs_next  = {data_byte, fs_e[31:8]};
            bpp      = fs_next[31:16];
            mag      = fs_next[31] ? (32'd0 - fs_next) : fs_next;
            case (pos_e)
                POS_SIG:
                begin
                    if (fs_next[31:16] != SIG_BM)
                    begin
                        push_c      = 1'b1;
                        ent.kind    = ENT_ERR;
                        ent.code    = ST_BAD_SIG;
                        halted_next = 1'b1;
                    end
                end
                POS_OFFSET:
                begin
                    off_next = fs_next;
                end
                POS_WIDTH:
                begin
                    if ((fs_next >> DIM_BITS) != 32'd0)
                    begin
                        push_c      = 1'b1;
                        ent.kind    = ENT_ERR;
                        ent.code    = ST_TOO_LARGE;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        w_next = fs_next[DIM_BITS-1:0];
                    end
                end
                POS_HEIGHT:
                begin
                    td_next = fs_next[31];
                    if ((mag >> DIM_BITS) != 32'd0)
                    begin
                        push_c      = 1'b1;
                        ent.kind    = ENT_ERR;
                        ent.code    = ST_TOO_LARGE;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        h_next = mag[DIM_BITS-1:0];
                    end
                end
                POS_BPP:
                begin
                    if (bpp > BPP_MAX)
                    begin
                        push_c      = 1'b1;
                        ent.kind    = ENT_ERR;
                        ent.code    = ST_TOO_MANY_BITS;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        d2_next  = (bpp == BPP_TWO);
                        dok_next = (bpp == BPP_ONE) || (bpp == BPP_TWO);
                    end
                end
                POS_COMP:
                begin
                    push_c      = 1'b1;
                    if (fs_next != 32'd0)
                    begin
                        ent.kind    = ENT_ERR;
                        ent.code    = ST_COMPRESSED;
                        halted_next = 1'b1;
                    end
                    else if (!dok_e)
                    begin
                        ent.kind    = ENT_ERR;
                        ent.code    = ST_BAD_DEPTH;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        // Hand the image geometry to the unpacker.
                        ent.kind      = ENT_START;
                        ent.top_down  = td_e;
                        ent.depth_two = d2_e;
                        left_next     = area;
                        if (w_e == '0 || h_e == '0)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (pos_e >= HDR_END && pos_e >= off_e)
                    begin
                        ppb = d2_e ? PPB_DEPTH2 : PPB_DEPTH1;
                        nb  = (left_e < LEFT_W'(ppb)) ? left_e[3:0] : ppb;
                        left_next     = left_e - LEFT_W'(nb);
                        push_c        = 1'b1;
                        ent.kind      = ENT_PIX;
                        ent.data      = data_byte;
                        ent.count     = nb;
                        ent.last      = (left_next == '0);
                        if (left_next == '0)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b1;
            pos_reg    <= '0;
            fs_reg     <= '0;
            off_reg    <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
            td_reg     <= 1'b0;
            d2_reg     <= 1'b0;
            dok_reg    <= 1'b0;
            left_reg   <= '0;
        end
        else if (accept)
        begin
            halted_reg <= halted_next;
            pos_reg    <= pos_next;
            fs_reg     <= fs_next;
            off_reg    <= off_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            td_reg     <= td_next;
            d2_reg     <= d2_next;
            dok_reg    <= dok_next;
            left_reg   <= left_next;
        end
    end

endmodule

`default_nettype wire

[src/bmpd_queue.sv]
// Small first-in first-out queue between the parser and the unpacker.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_queue
#(
    parameter int unsigned DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[src/bmpd_back.sv]
// Pixel unpacker: walks queued bytes one pixel per cycle unless stalled, drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_back
    import bmpd_pkg::*;
#(
    parameter int unsigned DIM_BITS = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire ent_t                q_ent,
    input  wire logic [DIM_BITS-1:0] q_w,
    input  wire logic [DIM_BITS-1:0] q_h,
    output logic                     q_pop,
    input  wire logic [CFG_W-1:0]    display_width,
    input  wire logic [CFG_W-1:0]    display_height,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [11:0]              pixel_col,
    output logic [11:0]              pixel_row,
    output logic [1:0]               pixel_color,
    output status_t                  status,
    output logic                     image_done
);

    localparam int unsigned CMP_W = (DIM_BITS > CFG_W) ? DIM_BITS : CFG_W;

    logic                advance;
    logic [DIM_BITS-1:0] w_reg, w_next;
    logic                td_reg, td_next;
    logic                d2_reg, d2_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS:0]   row_reg, row_next;
    logic [2:0]          k_reg, k_next;
    logic                ov_reg, ov_next;
    logic [11:0]         col_o_reg, col_o_next;
    logic [11:0]         row_o_reg, row_o_next;
    logic [1:0]          color_reg, color_next;
    status_t             status_reg, status_next;
    logic                done_reg, done_next;

    assign advance     = !ov_reg || out_ready;
    assign out_valid   = ov_reg;
    assign pixel_col   = col_o_reg;
    assign pixel_row   = row_o_reg;
    assign pixel_color = color_reg;
    assign status      = status_reg;
    assign image_done  = done_reg;

    always_comb
    begin
        logic [7:0]          sh;
        logic [1:0]          color;
        logic                visible;
        logic                last_px;
        logic [DIM_BITS-1:0] col_inc;

        w_next      = w_reg;
        td_next     = td_reg;
        d2_next     = d2_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        k_next      = k_reg;
        ov_next     = ov_reg && !out_ready;
        col_o_next  = col_o_reg;
        row_o_next  = row_o_reg;
        color_next  = color_reg;
        status_next = status_reg;
        done_next   = done_reg;
        q_pop       = 1'b0;

        // Pixel k of the head byte, MSB first.
        sh      = d2_reg ? (q_ent.data << {k_reg, 1'b0}) : (q_ent.data << k_reg);
        color   = d2_reg ? sh[7:6] : {1'b0, sh[7]};
        visible = !row_reg[DIM_BITS]
                  && (CMP_W'(col_reg) < CMP_W'(display_width))
                  && (CMP_W'(row_reg[DIM_BITS-1:0]) < CMP_W'(display_height));
        last_px = ({1'b0, k_reg} == (q_ent.count - 4'd1));
        col_inc = col_reg + 1'b1;

        if (advance && !q_empty)
        begin
            case (q_ent.kind)
                ENT_START:
                begin
                    q_pop    = 1'b1;
                    w_next   = q_w;
                    td_next  = q_ent.top_down;
                    d2_next  = q_ent.depth_two;
                    col_next = '0;
                    k_next   = '0;
                    row_next = q_ent.top_down ? '0 : ({1'b0, q_h} - 1'b1);
                end
                ENT_ERR:
                begin
                    q_pop       = 1'b1;
                    ov_next     = 1'b1;
                    col_o_next  = '0;
                    row_o_next  = '0;
                    color_next  = '0;
                    status_next = q_ent.code;
                    done_next   = 1'b1;
                end
                ENT_PIX:
                begin
                    if (visible)
                    begin
                        ov_next     = 1'b1;
                        col_o_next  = 12'(col_reg);
                        row_o_next  = 12'(row_reg[DIM_BITS-1:0]);
                        color_next  = color;
                        status_next = ST_PIXEL;
                        done_next   = q_ent.last && last_px;
                    end
                    if (col_inc == w_reg)
                    begin
                        col_next = '0;
                        row_next = td_reg ? row_reg + 1'b1 : row_reg - 1'b1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                    if (last_px)
                    begin
                        q_pop  = 1'b1;
                        k_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                default:
                begin
                    q_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= '0;
            td_reg  <= 1'b0;
            d2_reg  <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
            k_reg   <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            w_reg   <= w_next;
            td_reg  <= td_next;
            d2_reg  <= d2_next;
            col_reg <= col_next;
            row_reg <= row_next;
            k_reg   <= k_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_o_reg  <= col_o_next;
        row_o_reg  <= row_o_next;
        color_reg  <= color_next;
        status_reg <= status_next;
        done_reg   <= done_next;
    end

endmodule

`default_nettype wire

[src/bmp_indexed_pixel_decoder_unit.sv]
// Top level of the BMP indexed pixel decoder: configuration, parser, queue and unpacker.
//
// The block takes a BMP file one byte per transfer on byte_in, with file_start set on
// byte zero of each file, and gives pixel writes on pixel_out. Uncompressed 1-bit and
// 2-bit images are unpacked MSB first; each pixel inside the display window gives one
// transfer, and the last pixel of the image carries image_done if inside the window. A
// header error gives one transfer with a nonzero status and image_done, then bytes are
// dropped until the next file_start. The cfg channel writes display_width (index 0) and
// display_height (index 1); it is always ready and should only be used while idle.
// Header bytes are taken one per cycle while the queue is not full. The unpacker walks
// a pixel byte one pixel per cycle while pixel_out is not stalled, up to eight pixels at
// 1 bit per pixel and four at 2 bits per pixel; that loop sets the sustained rate. The
// first result of a byte passes through the queue and then the output register. A
// four-entry queue lets the parser keep taking bytes while the unpacker works. When
// pixel_out is stalled the unpacker holds, the queue fills, and byte_in.ready drops.
// After reset the display window is 800 by 480 and the parser waits for a file_start.
`timescale 1ns / 1ps
`default_nettype none

module bmp_indexed_pixel_decoder_unit
    import bmpd_pkg::*;
#(
    parameter int unsigned DIM_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmpd_byte_if.sink   byte_in,
    bmpd_pixel_if.source pixel_out,
    bmpd_cfg_if.sink    cfg
);

    localparam int unsigned Q_W = $bits(ent_t) + 2 * DIM_BITS;

    logic [CFG_W-1:0]    disp_w_reg, disp_h_reg;
    logic                push, q_full, q_empty, q_pop;
    ent_t                push_ent, head_ent;
    logic [DIM_BITS-1:0] push_w, push_h, head_w, head_h;
    logic [Q_W-1:0]      q_in, q_out;
    status_t             status;

    // Configuration registers; writes to unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_w_reg <= DISP_W_RESET;
            disp_h_reg <= DISP_H_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DISPLAY_WIDTH:  disp_w_reg <= cfg.data;
                CFG_DISPLAY_HEIGHT: disp_h_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    // The parser classifies each byte and, where one is due, queues a start, pixel or error entry.
    bmpd_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_in.valid),
        .in_ready   (byte_in.ready),
        .data_byte  (byte_in.data_byte),
        .file_start (byte_in.file_start),
        .q_full     (q_full),
        .push       (push),
        .ent        (push_ent),
        .ent_w      (push_w),
        .ent_h      (push_h)
    );

    assign q_in = {push_ent, push_w, push_h};

    bmpd_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {head_ent, head_w, head_h} = q_out;

    // The unpacker turns queued entries into results behind an output register.
    bmpd_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_ent          (head_ent),
        .q_w            (head_w),
        .q_h            (head_h),
        .q_pop          (q_pop),
        .display_width  (disp_w_reg),
        .display_height (disp_h_reg),
        .out_valid      (pixel_out.valid),
        .out_ready      (pixel_out.ready),
        .pixel_col      (pixel_out.pixel_col),
        .pixel_row      (pixel_out.pixel_row),
        .pixel_color    (pixel_out.pixel_color),
        .status         (status),
        .image_done     (pixel_out.image_done)
    );

    assign pixel_out.status = status;

endmodule

`default_nettype wire

[src/bmpd_checker.sv]
// Port-level checks for the BMP indexed pixel decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_port_checks
    import bmpd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [11:0] pixel_col,
    input wire logic [11:0] pixel_row,
    input wire logic [1:0]  pixel_color,
    input wire logic [2:0]  status,
    input wire logic        image_done
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_col) && $stable(pixel_row)
            && $stable(pixel_color) && $stable(status) && $stable(image_done))
        else $error("result changed while stalled");

    // An error result closes the file and carries no pixel.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PIXEL |-> image_done && pixel_col == 12'd0
            && pixel_row == 12'd0 && pixel_color == 2'd0)
        else $error("malformed error result");

    // Nothing is offered in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind bmp_indexed_pixel_decoder_unit bmpd_port_checks u_bmpd_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .pixel_col   (pixel_out.pixel_col),
    .pixel_row   (pixel_out.pixel_row),
    .pixel_color (pixel_out.pixel_color),
    .status      (pixel_out.status),
    .image_done  (pixel_out.image_done)
);

`default_nettype wire
